// ===== sv/itpa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itpa_pkg
// Shared constants, codes and control types of the padded ASCII formatter.
// ----------------------------------------------------------------------------
package itpa_pkg;

  // Widest field that can be produced; wider requests are clamped to it.
  localparam int MAX_WIDTH  = 32;
  // Entries of the digit buffer.
  localparam int TEXT_DEPTH = 12;

  // The pad_width field is 6 bits, so the usable field never exceeds 63.
  localparam int FIELD_MAX = (MAX_WIDTH < 63) ? MAX_WIDTH : 63;
  // Position counters hold any field length or text length.
  localparam int POS_W     = $clog2(FIELD_MAX + 1);
  localparam int IDX_W     = $clog2(TEXT_DEPTH);
  localparam int DIGIT_W   = 4;

  // Reciprocal of ten for the divide step: q = (mag * RECIP10) >> RECIP_SHIFT.
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ALPHA = 8'h37;  // 'A' minus ten

  typedef enum logic [1:0] {
    OP_CHAR = 2'd0,
    OP_DEC  = 2'd1,
    OP_HEX  = 2'd2,
    OP_OCT  = 2'd3
  } opcode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the input item
    logic conv;   // produce one digit
    logic size;   // work out pad and field length
    logic emit;   // load one character into the output register
  } itpa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_is_char;  // offered item is a character conversion
    logic conv_last;   // the current digit is the most significant one
    logic empty;       // the field has no characters at all
    logic out_free;    // the output register can take a character
    logic emit_last;   // the current character ends the field
  } itpa_status_t;

  // Upper-case ASCII of one hex digit.
  function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [7:0] d8;
    d8 = {4'd0, d};
    return (d < 4'd10) ? (CH_ZERO + d8) : (CH_ALPHA + d8);
  endfunction

endpackage
`default_nettype wire

// ===== sv/itpa_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itpa_in_if / itpa_out_if
// Valid/ready channels carrying the format requests and the characters.
// ----------------------------------------------------------------------------
interface itpa_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [1:0]         opcode;
  logic [5:0]         pad_width;
  logic               left_adjust;
  logic               zero_fill;

  modport source (output valid, value, opcode, pad_width, left_adjust, zero_fill,
                  input ready);
  modport sink   (input valid, value, opcode, pad_width, left_adjust, zero_fill,
                  output ready);
endinterface

interface itpa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last;

  modport source (output valid, char_out, last, input ready);
  modport sink   (input valid, char_out, last, output ready);
endinterface
`default_nettype wire

// ===== sv/integer_to_padded_ascii.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_padded_ascii
// Formats a 32-bit value as a character, decimal, hex or octal text field.
// ----------------------------------------------------------------------------
// One item is handled at a time. After acceptance the block produces its digits
// in its digit generator (decimal digits come from a shared reciprocal
// multiplier, one per cycle; up to 10 decimal, 8 hex or 11 octal digits; none
// for a character), sizes the field, and then emits the output characters,
// max(clamped pad_width, text length) of them, or one fewer for a character
// zero since its byte is never shown, at most MAX_WIDTH. The next item is
// accepted as soon as the final character sits in the output register.
module integer_to_padded_ascii
  import itpa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  itpa_in_if.sink   in_ch,
  itpa_out_if.source out_ch
);

  itpa_cmd_t    cmd;
  itpa_status_t status;
  logic         in_ready;
  logic         out_valid;
  logic [7:0]   out_char;
  logic         out_last;

  // Sequencer.
  itpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Digit generation and character output.
  itpa_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_value       (in_ch.value),
    .in_opcode      (in_ch.opcode),
    .in_pad_width   (in_ch.pad_width),
    .in_left_adjust (in_ch.left_adjust),
    .in_zero_fill   (in_ch.zero_fill),
    .out_ready      (out_ch.ready),
    .out_valid      (out_valid),
    .out_char       (out_char),
    .out_last       (out_last)
  );

  assign in_ch.ready     = in_ready;
  assign out_ch.valid    = out_valid;
  assign out_ch.char_out = out_char;
  assign out_ch.last     = out_last;

  // An accepted item blocks the input until its field is done.
  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input still ready after an item was accepted");

  // A character is never loaded over one that has not been taken.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_ch.valid || out_ch.ready))
    else $error("output register overwritten");

  // Loading the final character frees the input and marks the output last.
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && status.emit_last) |=> (in_ch.ready && out_ch.valid && out_ch.last))
    else $error("final character did not end the item");

endmodule
`default_nettype wire

// ===== sv/itpa_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itpa_ctrl
// Sequencer: accept an item, convert its digits, size the field, emit it.
// ----------------------------------------------------------------------------
module itpa_ctrl
  import itpa_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire itpa_status_t status,
  output itpa_cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SIZE = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = status.in_is_char ? S_SIZE : S_CONV;
        end
      end
      S_CONV: begin
        cmd.conv = 1'b1;
        if (status.conv_last) begin
          state_nxt = S_SIZE;
        end
      end
      S_SIZE: begin
        cmd.size  = 1'b1;
        state_nxt = status.empty ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = status.out_free;
        if (status.out_free && status.emit_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/itpa_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itpa_dp
// Datapath: digit generator, digit buffer, field sizing and output register.
// ----------------------------------------------------------------------------
module itpa_dp
  import itpa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire itpa_cmd_t          cmd,
  output itpa_status_t            status,
  input  wire logic signed [31:0] in_value,
  input  wire logic [1:0]         in_opcode,
  input  wire logic [5:0]         in_pad_width,
  input  wire logic               in_left_adjust,
  input  wire logic               in_zero_fill,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [7:0]              out_char,
  output logic                    out_last
);

  // Item registers.
  opcode_t            op_r;
  logic [31:0]        mag_r;
  logic [7:0]         byte_r;
  logic               neg_r;
  logic               left_r;
  logic               zfill_r;
  logic [POS_W-1:0]   width_r;

  // Digit buffer, least significant digit first.
  logic [DIGIT_W-1:0] dig_r [TEXT_DEPTH];
  logic [IDX_W-1:0]   cnt_r;

  // Field layout and emission position.
  logic [POS_W-1:0]   pad_r;
  logic [POS_W-1:0]   shown_r;
  logic [POS_W-1:0]   total_r;
  logic [POS_W-1:0]   pos_r;

  // Output register.
  logic               out_valid_r;
  logic [7:0]         char_r;
  logic               last_r;

  logic               is_char;
  logic [31:0]        in_bits;
  logic               in_neg;
  logic [POS_W-1:0]   in_width;

  logic [63:0]        prod;
  logic [31:0]        quot;
  logic [31:0]        rem_full;
  logic [DIGIT_W-1:0] digit;
  logic [31:0]        mag_nxt;

  logic [POS_W-1:0]   tlen;
  logic [POS_W-1:0]   shown;
  logic [POS_W-1:0]   pad;
  logic [POS_W-1:0]   total;

  logic               text_sel;
  logic [POS_W-1:0]   tpos;
  logic [POS_W-1:0]   idx_full;
  logic [IDX_W-1:0]   idx;
  logic [7:0]         pad_char;
  logic [7:0]         text_char;
  logic [7:0]         emit_char;

  assign is_char = (op_r == OP_CHAR);

  // Input capture: sign, magnitude and clamped field width.
  assign in_bits  = in_value;
  assign in_neg   = (opcode_t'(in_opcode) == OP_DEC) && in_bits[31];
  assign in_width = ({26'd0, in_pad_width} > 32'(FIELD_MAX)) ? POS_W'(FIELD_MAX)
                                                            : POS_W'(in_pad_width);

  // Digit step: divide by ten through the reciprocal, or shift by radix bits.
  assign prod     = {32'd0, mag_r} * {32'd0, RECIP10};
  assign quot     = 32'(prod[63:RECIP_SHIFT]);
  assign rem_full = mag_r - ((quot << 3) + (quot << 1));

  always_comb begin
    case (op_r)
      OP_DEC: begin
        digit   = rem_full[DIGIT_W-1:0];
        mag_nxt = quot;
      end
      OP_HEX: begin
        digit   = mag_r[3:0];
        mag_nxt = mag_r >> 4;
      end
      OP_OCT: begin
        digit   = {1'b0, mag_r[2:0]};
        mag_nxt = mag_r >> 3;
      end
      default: begin
        digit   = '0;
        mag_nxt = '0;
      end
    endcase
  end

  // Field sizing. A character zero counts as text but is not shown.
  assign tlen  = is_char ? POS_W'(1) : (POS_W'(cnt_r) + POS_W'(neg_r));
  assign shown = is_char ? POS_W'(byte_r != 8'd0) : tlen;
  assign pad   = (width_r > tlen) ? (width_r - tlen) : '0;
  assign total = pad + shown;

  // Character at the current position.
  assign text_sel  = left_r ? (pos_r < shown_r) : (pos_r >= pad_r);
  assign tpos      = left_r ? pos_r : (pos_r - pad_r);
  assign idx_full  = POS_W'(cnt_r) + POS_W'(neg_r) - POS_W'(1) - tpos;
  assign idx       = idx_full[IDX_W-1:0];
  assign pad_char  = zfill_r ? CH_ZERO : CH_SPACE;

  always_comb begin
    if (is_char) begin
      text_char = byte_r;
    end else if (neg_r && (tpos == '0)) begin
      text_char = CH_MINUS;
    end else begin
      text_char = digit_char(dig_r[idx]);
    end
  end

  assign emit_char = text_sel ? text_char : pad_char;

  // Item, digit and layout registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= opcode_t'(in_opcode);
      mag_r   <= in_neg ? (32'd0 - in_bits) : in_bits;
      byte_r  <= in_bits[7:0];
      neg_r   <= in_neg;
      left_r  <= in_left_adjust;
      zfill_r <= in_zero_fill;
      width_r <= in_width;
      cnt_r   <= '0;
    end
    if (cmd.conv) begin
      dig_r[cnt_r] <= digit;
      cnt_r        <= cnt_r + IDX_W'(1);
      mag_r        <= mag_nxt;
    end
    if (cmd.size) begin
      pad_r   <= pad;
      shown_r <= shown;
      total_r <= total;
      pos_r   <= '0;
    end
    if (cmd.emit) begin
      pos_r <= pos_r + POS_W'(1);
    end
  end

  // Output register: a character waits here while the next one is prepared.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      char_r <= emit_char;
      last_r <= status.emit_last;
    end
  end

  // Status to the controller.
  assign status.in_is_char = (opcode_t'(in_opcode) == OP_CHAR);
  assign status.conv_last  = (mag_nxt == 32'd0);
  assign status.empty      = (total == '0);
  assign status.out_free   = !out_valid_r || out_ready;
  assign status.emit_last  = (pos_r == (total_r - POS_W'(1)));

  assign out_valid = out_valid_r;
  assign out_char  = char_r;
  assign out_last  = last_r;

endmodule
`default_nettype wire
